// File: sv/rmc_pkg.sv
package rmc_pkg;

    // Event type of relative motion
    localparam logic [7:0] REL_TYPE = 8'd2;

    // Input item commands
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // What one processed item asks of the output side
    typedef logic [1:0] res_kind_t;
    localparam res_kind_t RES_NONE  = 2'd0;
    localparam res_kind_t RES_FWD   = 2'd1;
    localparam res_kind_t RES_FLUSH = 2'd2;

    // Configuration register map
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_INTERVAL = 3'd0;
    localparam logic [15:0] INTERVAL_RESET = 16'd10;

    typedef struct packed {
        res_kind_t          kind;
        logic [7:0]         ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
        logic               ev_sync;
    } step_res_t;

    typedef struct packed {
        logic busy;
        logic accept_ok;
    } emit_stat_t;

    // Axis codes in axis order: X, Y, WHEEL, HWHEEL, then the extra axes.
    function automatic logic [15:0] axis_code(input logic [2:0] idx);
        logic [15:0] code;
        case (idx)
            3'd0:    code = 16'd0;
            3'd1:    code = 16'd1;
            3'd2:    code = 16'd8;
            3'd3:    code = 16'd6;
            3'd4:    code = 16'd2;
            3'd5:    code = 16'd3;
            3'd6:    code = 16'd4;
            default: code = 16'd5;
        endcase
        return code;
    endfunction

endpackage

// File: sv/rmc_accum.sv
module rmc_accum
    import rmc_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic               cmd,
    input  logic [7:0]         ev_type,
    input  logic [15:0]        ev_code,
    input  logic signed [31:0] ev_value,
    input  logic               ev_sync,
    input  logic [15:0]        interval,
    output step_res_t          res,
    output logic [AXIS_COUNT-1:0] flush_mask,
    output logic [31:0]        sums [AXIS_COUNT]
);

    logic [31:0]           sums_reg  [AXIS_COUNT];
    logic [31:0]           sums_next [AXIS_COUNT];
    logic                  armed_reg;
    logic                  armed_next;
    logic [15:0]           ticks_reg;
    logic [15:0]           ticks_next;
    logic [AXIS_COUNT-1:0] hit;
    logic                  expire;

    always_comb
    begin
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            hit[i]        = (ev_type == REL_TYPE) && (ev_code == axis_code(3'(i)));
            flush_mask[i] = (sums_reg[i] != 32'd0);
            sums[i]       = sums_reg[i];
        end
        expire = armed_reg && (ticks_reg <= 16'd1);

        res.ev_type  = ev_type;
        res.ev_code  = ev_code;
        res.ev_value = ev_value;
        res.ev_sync  = ev_sync;
        if (cmd == CMD_TICK)
        begin
            res.kind = (expire && (|flush_mask)) ? RES_FLUSH : RES_NONE;
        end
        else
        begin
            res.kind = (|hit) ? RES_NONE : RES_FWD;
        end
    end

    always_comb
    begin
        sums_next  = sums_reg;
        armed_next = armed_reg;
        ticks_next = ticks_reg;
        if (go)
        begin
            if (cmd == CMD_TICK)
            begin
                if (expire)
                begin
                    armed_next = 1'b0;
                    ticks_next = 16'd0;
                    for (int i = 0; i < AXIS_COUNT; i++)
                    begin
                        sums_next[i] = 32'd0;
                    end
                end
                else if (armed_reg)
                begin
                    ticks_next = ticks_reg - 16'd1;
                end
            end
            else
            begin
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    if (hit[i])
                    begin
                        sums_next[i] = sums_reg[i] + unsigned'(ev_value);
                    end
                end
                if ((|hit) && !armed_reg)
                begin
                    armed_next = 1'b1;
                    ticks_next = (interval == 16'd0) ? 16'd1 : interval;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            ticks_reg <= 16'd0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                sums_reg[i] <= 32'd0;
            end
        end
        else
        begin
            armed_reg <= armed_next;
            ticks_reg <= ticks_next;
            sums_reg  <= sums_next;
        end
    end

endmodule

// File: sv/rmc_emit.sv
module rmc_emit
    import rmc_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  step_res_t          res,
    input  logic [AXIS_COUNT-1:0] flush_mask,
    input  logic [31:0]        sums [AXIS_COUNT],
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         out_type,
    output logic [15:0]        out_code,
    output logic signed [31:0] out_value,
    output logic               out_sync,
    output logic               last_of_run,
    output emit_stat_t         stat
);

    localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    logic                  vld_reg;
    logic                  vld_next;
    logic [7:0]            type_reg;
    logic [7:0]            type_next;
    logic [15:0]           code_reg;
    logic [15:0]           code_next;
    logic [31:0]           value_reg;
    logic [31:0]           value_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  sync_reg;
    logic                  sync_next;
    logic [AXIS_COUNT-1:0] mask_reg;
    logic [AXIS_COUNT-1:0] mask_next;
    logic [31:0]           vals_reg  [AXIS_COUNT];
    logic [31:0]           vals_next [AXIS_COUNT];

    logic                  out_free;
    logic                  draining;
    logic [AXIS_COUNT-1:0] src_mask;
    logic [AXIS_COUNT-1:0] pick_oh;
    logic [AXIS_COUNT-1:0] rest;
    logic [IDX_W-1:0]      pick;
    logic [31:0]           pick_val;

    always_comb
    begin
        out_free = !vld_reg || !out_stall;
        draining = (mask_reg != '0);
        src_mask = draining ? mask_reg : flush_mask;

        // Lowest remaining axis goes first
        pick    = '0;
        pick_oh = '0;
        for (int i = AXIS_COUNT - 1; i >= 0; i--)
        begin
            if (src_mask[i])
            begin
                pick    = IDX_W'(i);
                pick_oh = '0;
                pick_oh[i] = 1'b1;
            end
        end
        rest     = src_mask & ~pick_oh;
        pick_val = draining ? vals_reg[pick] : sums[pick];

        stat.busy      = draining;
        stat.accept_ok = out_free && !draining;
    end

    always_comb
    begin
        vld_next   = vld_reg;
        type_next  = type_reg;
        code_next  = code_reg;
        value_next = value_reg;
        sync_next  = sync_reg;
        last_next  = last_reg;
        mask_next  = mask_reg;
        vals_next  = vals_reg;
        if (out_free)
        begin
            if (draining || (load && (res.kind == RES_FLUSH)))
            begin
                vld_next   = 1'b1;
                type_next  = REL_TYPE;
                code_next  = axis_code(3'(pick));
                value_next = pick_val;
                sync_next  = (rest == '0);
                last_next  = (rest == '0);
                mask_next  = rest;
                if (!draining)
                begin
                    vals_next = sums;
                end
            end
            else if (load && (res.kind == RES_FWD))
            begin
                vld_next   = 1'b1;
                type_next  = res.ev_type;
                code_next  = res.ev_code;
                value_next = unsigned'(res.ev_value);
                sync_next  = res.ev_sync;
                last_next  = 1'b1;
            end
            else
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        code_reg  <= code_next;
        value_reg <= value_next;
        sync_reg  <= sync_next;
        last_reg  <= last_next;
        vals_reg  <= vals_next;
    end

    assign out_valid   = vld_reg;
    assign out_type    = type_reg;
    assign out_code    = code_reg;
    assign out_value   = signed'(value_reg);
    assign out_sync    = sync_reg;
    assign last_of_run = last_reg;

endmodule

// File: sv/relative_motion_coalescer_core.sv
// Relative motion coalescer.
// Input channel (in_valid, in_stall, cmd and ev_*) carries either an input event
// or a one millisecond tick. A relative X, Y, WHEEL or HWHEEL event is summed
// into its axis and, if no countdown runs, arms one of interval_ticks ticks;
// every other event is forwarded unchanged. When the countdown expires, each
// non-zero axis sum leaves as one transaction, in axis order, with sync and
// last_of_run set on the final one.
// Output channel (out_valid, out_stall, out_*) presents one result per cycle
// while out_stall is low. A forwarded event or the first flushed axis passes
// through the input and output registers; further axes follow one per cycle.
// Throughput: one input transaction per cycle. The input is held off while a
// flush still has axes to send or while a result is held by out_stall; items
// that give no result (motion, ticks before expiry) pass even then.
// The APB port holds interval_ticks at byte address 0 (reset value 10).
// Reset clears the sums, disarms the countdown and empties both registers.
// While out_stall is high the presented result holds still.
module relative_motion_coalescer_core
    import rmc_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [7:0]         ev_type,
    input  logic [15:0]        ev_code,
    input  logic signed [31:0] ev_value,
    input  logic               ev_sync,
    // Output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_type,
    output logic [15:0]        out_code,
    output logic signed [31:0] out_value,
    output logic               out_sync,
    output logic               last_of_run,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Input register: one accepted transaction waiting for processing.
    logic               in_vld_reg;
    logic               in_vld_next;
    logic               cmd_reg;
    logic [7:0]         type_reg;
    logic [15:0]        code_reg;
    logic signed [31:0] value_reg;
    logic               sync_reg;

    logic [15:0]        interval_reg;
    logic [15:0]        interval_next;

    step_res_t             res;
    emit_stat_t            stat;
    logic [AXIS_COUNT-1:0] flush_mask;
    logic [31:0]           sums [AXIS_COUNT];
    logic                  go;
    logic                  in_take;

    // An item that produces no result can always retire. One that produces a
    // result needs the output register free and no flush still draining.
    assign go       = in_vld_reg && ((res.kind == RES_NONE) || stat.accept_ok);
    assign in_stall = in_vld_reg && !go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (go)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= cmd;
            type_reg  <= ev_type;
            code_reg  <= ev_code;
            value_reg <= ev_value;
            sync_reg  <= ev_sync;
        end
    end

    // Configuration register. The interval is only sampled when a countdown is
    // armed, so a write while armed takes effect at the next arming.
    always_comb
    begin
        interval_next = interval_reg;
        if (psel && penable && pwrite && (paddr == ADDR_INTERVAL))
        begin
            interval_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            interval_reg <= interval_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_INTERVAL) ? {16'd0, interval_reg} : 32'd0;

    rmc_accum #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .cmd        (cmd_reg),
        .ev_type    (type_reg),
        .ev_code    (code_reg),
        .ev_value   (value_reg),
        .ev_sync    (sync_reg),
        .interval   (interval_reg),
        .res        (res),
        .flush_mask (flush_mask),
        .sums       (sums)
    );

    rmc_emit #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (go),
        .res         (res),
        .flush_mask  (flush_mask),
        .sums        (sums),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_type    (out_type),
        .out_code    (out_code),
        .out_value   (out_value),
        .out_sync    (out_sync),
        .last_of_run (last_of_run),
        .stat        (stat)
    );

`ifndef ASSERT_OFF
    // Axes still queued for a flush imply a flushed axis is being presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> out_valid)
    else $error("flush axes pending with no result presented");

    // A result that is not the last of its run must have more axes queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> stat.busy)
    else $error("non-final result with nothing queued behind it");

    // Only flushed axes come in runs of more than one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (out_type == REL_TYPE && !out_sync))
    else $error("non-final result is not a plain relative axis");

    // A held-off transaction stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_vld_reg)
    else $error("input register lost a stalled transaction");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmc_pkg::*;

    // The block is built with the four standard pointer axes.
    localparam int N_AXES = 4;

    // Axis codes in the order in which a flush emits them.
    localparam logic [15:0] CODE_X      = 16'd0;
    localparam logic [15:0] CODE_Y      = 16'd1;
    localparam logic [15:0] CODE_WHEEL  = 16'd8;
    localparam logic [15:0] CODE_HWHEEL = 16'd6;

    // Event types used by the stimulus besides relative motion.
    localparam logic [7:0] EV_SYN = 8'd0;
    localparam logic [7:0] EV_KEY = 8'd1;

    // Length of the long output hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 300;

    // One emitted event as it leaves the output channel.
    typedef struct packed {
        logic [7:0]  etype;
        logic [15:0] ecode;
        logic [31:0] evalue;
        logic        esync;
        logic        elast;
    } motion_ev_t;

    // Behavioural copy of the coalescer. Every accepted input transaction is
    // fed to take_item, which queues the events that the block must emit;
    // match_output compares each emitted event with the oldest queued one.
    class coalesce_model;
        logic [15:0] interval;
        logic [31:0] sums [N_AXES];
        bit          armed;
        logic [15:0] ticks_left;
        motion_ev_t  due[$];
        int          faults;

        function new();
            interval   = INTERVAL_RESET;
            armed      = 1'b0;
            ticks_left = '0;
            faults     = 0;
            for (int i = 0; i < N_AXES; i++)
                sums[i] = '0;
        endfunction

        function logic [15:0] code_of(int idx);
            case (idx)
                0:       return CODE_X;
                1:       return CODE_Y;
                2:       return CODE_WHEEL;
                default: return CODE_HWHEEL;
            endcase
        endfunction

        // Expiry: every non-zero sum goes out in axis order, the last one
        // carrying sync, and the countdown is disarmed.
        function void drain_sums();
            int         last_idx;
            motion_ev_t r;
            last_idx = -1;
            for (int i = 0; i < N_AXES; i++)
                if (sums[i] != 0)
                    last_idx = i;
            for (int i = 0; i <= last_idx; i++)
            begin
                if (sums[i] != 0)
                begin
                    r.etype  = REL_TYPE;
                    r.ecode  = code_of(i);
                    r.evalue = sums[i];
                    r.esync  = (i == last_idx);
                    r.elast  = (i == last_idx);
                    due.push_back(r);
                end
            end
            for (int i = 0; i < N_AXES; i++)
                sums[i] = '0;
            armed      = 1'b0;
            ticks_left = '0;
        endfunction

        function void take_item(logic c, logic [7:0] t, logic [15:0] k,
                                logic [31:0] v, logic s);
            motion_ev_t r;
            if (c == CMD_TICK)
            begin
                if (armed)
                begin
                    if (ticks_left <= 16'd1)
                        drain_sums();
                    else
                        ticks_left--;
                end
                return;
            end
            if (t == REL_TYPE)
            begin
                for (int i = 0; i < N_AXES; i++)
                begin
                    if (k == code_of(i))
                    begin
                        sums[i] += v;
                        if (!armed)
                        begin
                            armed      = 1'b1;
                            ticks_left = (interval == 16'd0) ? 16'd1 : interval;
                        end
                        return;
                    end
                end
            end
            r.etype  = t;
            r.ecode  = k;
            r.evalue = v;
            r.esync  = s;
            r.elast  = 1'b1;
            due.push_back(r);
        endfunction

        function void match_output(logic [7:0] t, logic [15:0] k, logic [31:0] v,
                                   logic s, logic l);
            motion_ev_t got;
            motion_ev_t want;
            got = {t, k, v, s, l};
            if (due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: type %0d code %0d value %0d sync %0b last %0b",
                             t, k, $signed(v), s, l);
                return;
            end
            want = due.pop_front();
            if (got !== want)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $write("mismatch: expected type %0d code %0d value %0d sync %0b last %0b,",
                           want.etype, want.ecode, $signed(want.evalue), want.esync,
                           want.elast);
                    $display(" got type %0d code %0d value %0d sync %0b last %0b",
                             t, k, $signed(v), s, l);
                end
            end
        endfunction
    endclass

    // Every input of the block starts from a known value.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               cmd = CMD_EVENT;
    logic [7:0]         ev_type = '0;
    logic [15:0]        ev_code = '0;
    logic signed [31:0] ev_value = '0;
    logic               ev_sync = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               out_sync;
    logic               last_of_run;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    coalesce_model model = new();

    // calm switches off random idling on both sides; hold_req asks the
    // receiver for one long hold-off, which it then counts down itself.
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int items_sent = 0;

    relative_motion_coalescer_core #(.AXIS_COUNT(N_AXES)) dut (.*);

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver. Signals are sampled as they stood just before the edge, so a
    // transaction is taken when out_valid was high and out_stall was low.
    // The stall for the next cycle is then chosen: a pending hold-off wins,
    // otherwise a stall is drawn with a chance of eight in a hundred unless calm.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            model.match_output(out_type, out_code, out_value, out_sync, last_of_run);
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 8);
    end

    // Occasionally leave the input channel idle after a transaction. The pause
    // always waits on a clock edge, so valid is never lowered and raised again
    // within the same time step.
    task automatic maybe_pause();
        if (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Present one input transaction and hold it until the block takes it.
    // Called just after a rising edge; returns after acceptance and any pause.
    task automatic offer(input logic c, input logic [7:0] t, input logic [15:0] k,
                         input logic [31:0] v, input logic s);
        in_valid <= 1'b1;
        cmd      <= c;
        ev_type  <= t;
        ev_code  <= k;
        ev_value <= v;
        ev_sync  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model.take_item(c, t, k, v, s);
        items_sent++;
        maybe_pause();
    endtask

    // A tick carries random rubbish in the event fields, which must be ignored.
    task automatic offer_tick();
        offer(CMD_TICK, 8'($urandom), 16'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic offer_motion(input int axis, input logic [31:0] delta);
        offer(CMD_EVENT, REL_TYPE, model.code_of(axis), delta, 1'($urandom));
    endtask

    // Deltas are mostly small, with the odd extreme or fully random value so
    // that the sums wrap now and then.
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return 32'($urandom_range(200)) - 32'd100;
        endcase
    endfunction

    // An event that is forwarded at once: relative motion on a code that is
    // not coalesced, a key, a sync report or something entirely random.
    task automatic offer_other();
        case ($urandom_range(3))
            0:
            begin
                if ($urandom_range(1) == 0)
                    offer(CMD_EVENT, REL_TYPE, 16'($urandom_range(2, 5)), pick_delta(),
                          1'($urandom));
                else
                    offer(CMD_EVENT, REL_TYPE, 16'($urandom), $urandom, 1'($urandom));
            end
            1:       offer(CMD_EVENT, EV_KEY, 16'($urandom), $urandom_range(2), 1'($urandom));
            2:       offer(CMD_EVENT, 8'($urandom), 16'($urandom), $urandom, 1'($urandom));
            default: offer(CMD_EVENT, EV_SYN, 16'd0, 32'd0, 1'b1);
        endcase
    endtask

    // One burst of pointer activity: a few motion events, sometimes mixed
    // with forwarded events, followed by a run of ticks that may or may not
    // reach the flush.
    task automatic gesture();
        int span;
        span = (model.interval == 16'd0) ? 1 : int'(model.interval);
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(3) == 0)
                offer_other();
            offer_motion($urandom_range(N_AXES - 1), pick_delta());
        end
        repeat ($urandom_range(0, span + 2))
        begin
            if ($urandom_range(9) == 0)
                offer_other();
            offer_tick();
        end
    endtask

    task automatic random_run(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            gesture();
    endtask

    // Stop offering and wait until every expected result has left the
    // block, then keep waiting so that items with no result have been absorbed
    // before the configuration is touched.
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (model.due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    // APB write of interval_ticks: setup cycle, then access cycle until
    // pready. The upper data bits are random and must be ignored.
    task automatic write_interval(input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_INTERVAL;
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model.interval = val;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the interval left at its reset value of
        // ten. A tick while nothing is armed gives nothing; field extremes
        // are forwarded; then every axis accumulates, one wheel sum wraps,
        // and a later motion event must not restart the running countdown.
        offer_tick();
        offer(CMD_EVENT, EV_SYN, 16'd0, 32'd0, 1'b0);
        offer(CMD_EVENT, 8'hFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
        offer(CMD_EVENT, REL_TYPE, 16'd2, 32'h8000_0000, 1'b0);
        offer(CMD_EVENT, REL_TYPE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        offer_motion(0, 32'd5);
        offer_motion(1, 32'hFFFF_FFFF);
        offer_motion(2, 32'h7FFF_FFFF);
        offer_motion(2, 32'd1);
        offer_motion(3, 32'h8000_0000);
        offer(CMD_EVENT, EV_KEY, 16'h0110, 32'd1, 1'b0);
        repeat (5) offer_tick();
        offer_motion(0, 32'd3);
        repeat (5) offer_tick();
        settle();

        // A zero interval behaves as one tick. Motion that cancels out keeps
        // the flush armed, but the flush then has nothing to emit.
        write_interval(16'd0);
        offer_motion(1, 32'd7);
        offer_motion(1, -32'sd7);
        offer_tick();
        offer_tick();
        offer_motion(3, 32'd9);
        offer_tick();
        settle();

        // Rewriting the interval while a countdown runs leaves that
        // countdown alone; the flush still comes after three ticks.
        write_interval(16'd3);
        offer_motion(0, 32'd1);
        settle();
        write_interval(16'hFFFF);
        repeat (3) offer_tick();
        settle();

        // Random traffic under several interval settings.
        write_interval(16'd1);
        random_run(15);
        settle();

        // During this run the receiver holds off for a long stretch while
        // forwarded events keep coming, so the block fills and stalls its
        // input.
        write_interval(16'd4);
        random_run(5);
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (25) offer_other();
        calm = 1'b0;
        random_run(10);
        settle();

        // A stretch with no idling at all on either side.
        write_interval(16'($urandom_range(2, 7)));
        calm = 1'b1;
        random_run(15);
        settle();
        calm = 1'b0;

        write_interval(16'd3);
        random_run(15);
        settle();

        if (model.due.size() != 0)
            $display("results still outstanding at the end: %0d", model.due.size());
        if (model.faults == 0 && model.due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial
    begin
        #200_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/rmc_pkg.sv
sv/rmc_accum.sv
sv/rmc_emit.sv
sv/relative_motion_coalescer_core.sv
tb/sv/testbench.sv
